### src/dth_pkg.sv
package dth_pkg;

    // geometry and storage sizes
    localparam int COLUMNS_PER_ARM  = 145;
    localparam int ARM_COUNT        = 2;
    localparam int HITS_PER_COUNTER = 16;
    localparam int MAX_RESULTS      = 16;

    localparam int NUM_COUNTERS = ARM_COUNT * COLUMNS_PER_ARM;
    localparam int CTR_W        = $clog2(NUM_COUNTERS);
    localparam int SLOT_W       = (HITS_PER_COUNTER > 1) ? $clog2(HITS_PER_COUNTER) : 1;
    localparam int CNT_W        = $clog2(HITS_PER_COUNTER + 1);
    localparam int SLOT_DEPTH   = NUM_COUNTERS * (2 ** SLOT_W);

    // field widths
    localparam int ID_W     = 9;
    localparam int TIME_W   = 48;
    localparam int ENERGY_W = 32;
    localparam int TRACK_W  = 24;
    localparam int PART_W   = 8;
    localparam int WIN_W    = 20;
    localparam int MAXH_W   = 5;
    localparam int COL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LATE_LIMIT   = 2'd3;

    // operations
    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [TIME_W-1:0]   hit_time;
        logic [TRACK_W-1:0]  track;
        logic [PART_W-1:0]   particle;
    } hit_t;

    typedef struct packed {
        logic             ovf;
        logic [CNT_W-1:0] count;
    } meta_t;

    localparam int HIT_W  = $bits(hit_t);
    localparam int META_W = $bits(meta_t);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_SCAN,
        ST_PLACE,
        ST_SHIFT,
        ST_INSERT,
        ST_CNT,
        ST_EMIT_RD,
        ST_EMIT_CHK,
        ST_EMPTY,
        ST_BAD
    } state_t;

endpackage

### src/dth_ram.sv
module dth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // one registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/detector_tile_hit_merger.sv
// deposit: reads the counter's metadata, then either stores the hit at once on an empty
//   list or compares the stored hits in turn, merging or shifting later hits up to insert
// readout: counts the qualifying stored hits, then visits the stored hits and emits each
//   qualifying one, waiting on output stalls; ready is high only between items, one at a time
// after reset a clearing pass over all NUM_COUNTERS (290) entries zeroes the counter
//   table before the first word is taken; configuration writes are taken always
module detector_tile_hit_merger (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dth_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dth_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [dth_pkg::ID_W-1:0]        counter_id,
    input  logic [dth_pkg::TIME_W-1:0]      time_in_ps,
    input  logic [dth_pkg::TIME_W-1:0]      time_out_ps,
    input  logic [dth_pkg::ENERGY_W-1:0]    energy_ev,
    input  logic [dth_pkg::TRACK_W-1:0]     track_number,
    input  logic [dth_pkg::PART_W-1:0]      particle_type,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            arm,
    output logic [dth_pkg::COL_W-1:0]       column,
    output logic [dth_pkg::ENERGY_W-1:0]    hit_energy_ev,
    output logic [dth_pkg::TIME_W-1:0]      hit_time_ps,
    output logic [dth_pkg::TRACK_W-1:0]     hit_track,
    output logic [dth_pkg::PART_W-1:0]      hit_particle,
    output logic                            hit_valid,
    output logic                            overflow,
    output logic                            last
);

    import dth_pkg::*;

    localparam logic [CNT_W-1:0] HITS_C  = CNT_W'(HITS_PER_COUNTER);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CTR_W-1:0] CTR_TOP = CTR_W'(NUM_COUNTERS - 1);

    state_t state_reg, state_next;

    // configuration
    logic [WIN_W-1:0]    win_reg;
    logic [ENERGY_W-1:0] thr_reg;
    logic [MAXH_W-1:0]   maxh_reg;
    logic [TIME_W-1:0]   lim_reg;

    // item context
    logic                op_reg,  op_next;
    logic [CTR_W-1:0]    ctr_reg, ctr_next;
    logic                arm_reg, arm_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [TIME_W-1:0]   t_reg,   t_next;
    logic [ENERGY_W-1:0] e_reg,   e_next;
    logic [TRACK_W-1:0]  trk_reg, trk_next;
    logic [PART_W-1:0]   par_reg, par_next;
    logic [CNT_W-1:0]    n_reg,   n_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]    q_reg, q_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    emit_reg, emit_next;
    logic [CTR_W-1:0]    clr_reg, clr_next;

    // output word
    logic                out_valid_reg, out_valid_next;
    logic                o_arm_reg, o_arm_next;
    logic [COL_W-1:0]    o_col_reg, o_col_next;
    hit_t                o_hit_reg, o_hit_next;
    logic                o_hv_reg, o_hv_next;
    logic                o_ovf_reg, o_ovf_next;
    logic                o_last_reg, o_last_next;

    // memories
    logic                     hit_we;
    logic [CTR_W+SLOT_W-1:0]  hit_waddr, hit_raddr;
    hit_t                     hit_wdata, hit_rd;
    logic                     meta_we;
    logic [CTR_W-1:0]         meta_waddr, meta_raddr;
    meta_t                    meta_wdata, meta_rd;

    // input decode
    logic [ID_W-1:0]     id_m1;
    logic                id_ok;
    logic [CTR_W-1:0]    in_ctr;
    logic                in_arm;
    logic [COL_W-1:0]    in_col;
    logic [TIME_W:0]     t_sum;
    logic [TIME_W-1:0]   in_t;

    // datapath conditions
    logic                ht_gt, near, chk_last, merge_now, break_hit, full, cnt_done;
    logic                qual, out_free, out_load;
    logic [TIME_W-1:0]   t_diff;
    logic [ENERGY_W:0]   e_sum;
    logic [ENERGY_W-1:0] e_sat;
    logic [CNT_W-1:0]    neff, brk_pos, q_fin;
    logic [MAXH_W-1:0]   cap;
    logic [CNT_W:0]      cap_w;

    dth_ram #(.WIDTH(HIT_W), .DEPTH(SLOT_DEPTH)) u_hit_ram (
        .clk   (clk),
        .we    (hit_we),
        .waddr (hit_waddr),
        .wdata (hit_wdata),
        .raddr (hit_raddr),
        .rdata (hit_rd)
    );

    dth_ram #(.WIDTH(META_W), .DEPTH(NUM_COUNTERS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rd)
    );

    // counter id split into arm and column
    always_comb
    begin
        id_m1  = counter_id - ID_W'(1);
        id_ok  = (counter_id != '0) && (counter_id <= ID_W'(NUM_COUNTERS));
        in_ctr = id_m1[CTR_W-1:0];
        in_arm = 1'b0;
        in_col = COL_W'(in_ctr) + COL_W'(1);
        for (int a = 1; a < ARM_COUNT; a++)
        begin
            if ({1'b0, in_ctr} >= (CTR_W+1)'(a * COLUMNS_PER_ARM))
            begin
                in_arm = a[0];
                in_col = COL_W'(in_ctr - CTR_W'(a * COLUMNS_PER_ARM)) + COL_W'(1);
            end
        end
    end

    // hit time: midpoint, or entry time when exit is late
    always_comb
    begin
        t_sum = {1'b0, time_in_ps} + {1'b0, time_out_ps};
        in_t  = (time_out_ps > lim_reg) ? time_in_ps : t_sum[TIME_W:1];
    end

    // shared compare and add unit on the word read back
    always_comb
    begin
        ht_gt     = hit_rd.hit_time > t_reg;
        t_diff    = ht_gt ? (hit_rd.hit_time - t_reg) : (t_reg - hit_rd.hit_time);
        near      = t_diff < TIME_W'(win_reg);
        e_sum     = {1'b0, hit_rd.energy} + {1'b0, e_reg};
        e_sat     = e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
        qual      = hit_rd.energy > thr_reg;
        chk_last  = chk_valid_reg && ((chk_idx_reg + ONE_C) == n_reg);
        merge_now = chk_valid_reg && near;
        break_hit = chk_valid_reg && !near && (ht_gt || chk_last);
        brk_pos   = ht_gt ? chk_idx_reg : (chk_idx_reg + ONE_C);
        full      = n_reg >= HITS_C;
        neff      = full ? (HITS_C - ONE_C) : n_reg;
        cnt_done  = (rd_idx_reg == n_reg) && !chk_valid_reg;
        q_fin     = q_reg;
        out_free  = !out_valid_reg || out_ready;
        if (maxh_reg == '0)
        begin
            cap = MAXH_W'(1);
        end
        else if (maxh_reg > MAXH_W'(MAX_RESULTS))
        begin
            cap = MAXH_W'(MAX_RESULTS);
        end
        else
        begin
            cap = maxh_reg;
        end
        cap_w = (CNT_W+1)'(cap);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CTR_TOP)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_DEPOSIT)
                    begin
                        if (id_ok && (energy_ev != '0))
                        begin
                            state_next = ST_META;
                        end
                    end
                    else
                    begin
                        state_next = id_ok ? ST_META : ST_BAD;
                    end
                end
            end
            ST_META:
            begin
                if (op_reg == OP_READOUT)
                begin
                    state_next = ST_CNT;
                end
                else
                begin
                    state_next = (meta_rd.count == '0) ? ST_PLACE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (merge_now)
                begin
                    state_next = ST_IDLE;
                end
                else if (break_hit)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                priority if (full && (pos_reg >= HITS_C))
                begin
                    state_next = ST_IDLE;
                end
                else if (neff > pos_reg)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_SHIFT:
            begin
                if (!((wr_idx_reg - ONE_C) > pos_reg))
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            ST_CNT:
            begin
                if (cnt_done)
                begin
                    state_next = (q_fin == '0) ? ST_EMPTY : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_CHK;
            end
            ST_EMIT_CHK:
            begin
                priority if (!qual)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (out_free)
                begin
                    state_next = ((emit_reg + ONE_C) == k_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_EMPTY, ST_BAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next        = op_reg;
        ctr_next       = ctr_reg;
        arm_next       = arm_reg;
        col_next       = col_reg;
        t_next         = t_reg;
        e_next         = e_reg;
        trk_next       = trk_reg;
        par_next       = par_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        rd_idx_next    = rd_idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        pos_next       = pos_reg;
        wr_idx_next    = wr_idx_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        emit_next      = emit_reg;
        clr_next       = clr_reg;

        out_load    = 1'b0;
        o_arm_next  = o_arm_reg;
        o_col_next  = o_col_reg;
        o_hit_next  = o_hit_reg;
        o_hv_next   = o_hv_reg;
        o_ovf_next  = o_ovf_reg;
        o_last_next = o_last_reg;

        hit_we     = 1'b0;
        hit_waddr  = {ctr_reg, rd_idx_reg[SLOT_W-1:0]};
        hit_wdata  = hit_rd;
        hit_raddr  = {ctr_reg, rd_idx_reg[SLOT_W-1:0]};
        meta_we    = 1'b0;
        meta_waddr = ctr_reg;
        meta_wdata = '0;
        meta_raddr = ctr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                clr_next   = clr_reg + CTR_W'(1);
            end
            ST_IDLE:
            begin
                meta_raddr = in_ctr;
                if (in_valid)
                begin
                    op_next  = op;
                    ctr_next = in_ctr;
                    arm_next = in_arm;
                    col_next = in_col;
                    t_next   = in_t;
                    e_next   = energy_ev;
                    trk_next = track_number;
                    par_next = particle_type;
                end
            end
            ST_META:
            begin
                n_next         = meta_rd.count;
                ovf_next       = meta_rd.ovf;
                rd_idx_next    = '0;
                chk_valid_next = 1'b0;
                q_next         = '0;
                pos_next       = '0;
            end
            ST_SCAN, ST_CNT:
            begin
                // stream reads, check the word from the previous cycle
                if (rd_idx_reg < n_reg)
                begin
                    rd_idx_next    = rd_idx_reg + ONE_C;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (state_reg == ST_SCAN)
                begin
                    if (merge_now)
                    begin
                        hit_we             = 1'b1;
                        hit_waddr          = {ctr_reg, chk_idx_reg[SLOT_W-1:0]};
                        hit_wdata.energy   = e_sat;
                        hit_wdata.hit_time = ht_gt ? t_reg : hit_rd.hit_time;
                    end
                    else if (break_hit)
                    begin
                        pos_next = brk_pos;
                    end
                end
                else
                begin
                    if (chk_valid_reg && qual)
                    begin
                        q_next = q_reg + ONE_C;
                    end
                    if (cnt_done)
                    begin
                        rd_idx_next = '0;
                        emit_next   = '0;
                        if ({1'b0, q_fin} > cap_w)
                        begin
                            ovf_next = 1'b1;
                            k_next   = CNT_W'(cap);
                        end
                        else
                        begin
                            k_next = q_fin;
                        end
                    end
                end
            end
            ST_PLACE:
            begin
                // room check, then prime the first shift read
                ovf_next    = ovf_reg | full;
                n_next      = neff;
                wr_idx_next = neff;
                hit_raddr   = {ctr_reg, SLOT_W'(neff - ONE_C)};
                if (full && (pos_reg >= HITS_C))
                begin
                    meta_we    = 1'b1;
                    meta_wdata = '{ovf: 1'b1, count: n_reg};
                end
            end
            ST_SHIFT:
            begin
                hit_we      = 1'b1;
                hit_waddr   = {ctr_reg, wr_idx_reg[SLOT_W-1:0]};
                hit_wdata   = hit_rd;
                hit_raddr   = {ctr_reg, SLOT_W'(wr_idx_reg - CNT_W'(2))};
                wr_idx_next = wr_idx_reg - ONE_C;
            end
            ST_INSERT:
            begin
                hit_we     = 1'b1;
                hit_waddr  = {ctr_reg, pos_reg[SLOT_W-1:0]};
                hit_wdata  = '{energy: e_reg, hit_time: t_reg, track: trk_reg,
                               particle: par_reg};
                meta_we    = 1'b1;
                meta_wdata = '{ovf: ovf_reg, count: n_reg + ONE_C};
            end
            ST_EMIT_RD:
            begin
            end
            ST_EMIT_CHK:
            begin
                if (!qual)
                begin
                    rd_idx_next = rd_idx_reg + ONE_C;
                end
                else if (out_free)
                begin
                    out_load    = 1'b1;
                    o_arm_next  = arm_reg;
                    o_col_next  = col_reg;
                    o_hit_next  = hit_rd;
                    o_hv_next   = 1'b1;
                    o_ovf_next  = ovf_reg;
                    o_last_next = (emit_reg + ONE_C) == k_reg;
                    emit_next   = emit_reg + ONE_C;
                    rd_idx_next = rd_idx_reg + ONE_C;
                    if ((emit_reg + ONE_C) == k_reg)
                    begin
                        meta_we = 1'b1;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    o_arm_next  = arm_reg;
                    o_col_next  = col_reg;
                    o_hit_next  = '0;
                    o_hv_next   = 1'b0;
                    o_ovf_next  = ovf_reg;
                    o_last_next = 1'b1;
                    meta_we     = 1'b1;
                end
            end
            ST_BAD:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    o_arm_next  = 1'b0;
                    o_col_next  = '0;
                    o_hit_next  = '0;
                    o_hv_next   = 1'b0;
                    o_ovf_next  = 1'b0;
                    o_last_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ready) || out_load;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            win_reg       <= WIN_W'(25000);
            thr_reg       <= ENERGY_W'(10000);
            maxh_reg      <= MAXH_W'(16);
            lim_reg       <= TIME_W'(64'd1000000000000);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MERGE_WINDOW: win_reg  <= cfg_data[WIN_W-1:0];
                    REG_THRESHOLD:    thr_reg  <= cfg_data[ENERGY_W-1:0];
                    REG_MAX_HITS:     maxh_reg <= cfg_data[MAXH_W-1:0];
                    REG_LATE_LIMIT:   lim_reg  <= cfg_data[TIME_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ctr_reg       <= ctr_next;
        arm_reg       <= arm_next;
        col_reg       <= col_next;
        t_reg         <= t_next;
        e_reg         <= e_next;
        trk_reg       <= trk_next;
        par_reg       <= par_next;
        n_reg         <= n_next;
        ovf_reg       <= ovf_next;
        rd_idx_reg    <= rd_idx_next;
        chk_valid_reg <= chk_valid_next;
        chk_idx_reg   <= chk_idx_next;
        pos_reg       <= pos_next;
        wr_idx_reg    <= wr_idx_next;
        q_reg         <= q_next;
        k_reg         <= k_next;
        emit_reg      <= emit_next;
        o_arm_reg     <= o_arm_next;
        o_col_reg     <= o_col_next;
        o_hit_reg     <= o_hit_next;
        o_hv_reg      <= o_hv_next;
        o_ovf_reg     <= o_ovf_next;
        o_last_reg    <= o_last_next;
    end

    // ports
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign arm           = o_arm_reg;
    assign column        = o_col_reg;
    assign hit_energy_ev = o_hit_reg.energy;
    assign hit_time_ps   = o_hit_reg.hit_time;
    assign hit_track     = o_hit_reg.track;
    assign hit_particle  = o_hit_reg.particle;
    assign hit_valid     = o_hv_reg;
    assign overflow      = o_ovf_reg;
    assign last          = o_last_reg;

endmodule
